FILE: rtl/ltp_pkg.sv
`timescale 1ns / 1ps

package ltp_pkg;

  // Truncation limits for text TLVs and for chassis and port IDs.
  localparam int unsigned DESCR_LEN = 64;
  localparam int unsigned ID_LEN    = 32;

  // Result queue: one accepted byte can push up to three results.
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  typedef enum logic [3:0] {
    PH_CH_HDR1  = 4'd0,
    PH_CH_HDR2  = 4'd1,
    PH_CH_SUB   = 4'd2,
    PH_CH_ID    = 4'd3,
    PH_PT_HDR1  = 4'd4,
    PH_PT_HDR2  = 4'd5,
    PH_PT_SUB   = 4'd6,
    PH_PT_ID    = 4'd7,
    PH_TTL_HDR1 = 4'd8,
    PH_TTL_HDR2 = 4'd9,
    PH_TTL_VAL  = 4'd10,
    PH_OPT_HDR1 = 4'd11,
    PH_OPT_HDR2 = 4'd12,
    PH_OPT_VAL  = 4'd13
  } phase_e;

  localparam logic [3:0] K_CH_SUB  = 4'd0;
  localparam logic [3:0] K_CH_BYTE = 4'd1;
  localparam logic [3:0] K_PT_SUB  = 4'd2;
  localparam logic [3:0] K_PT_BYTE = 4'd3;
  localparam logic [3:0] K_TTL     = 4'd4;
  localparam logic [3:0] K_TEXT0   = 4'd5;
  localparam logic [3:0] K_LEN     = 4'd8;
  localparam logic [3:0] K_CAPS    = 4'd9;
  localparam logic [3:0] K_CAPS_EN = 4'd10;
  localparam logic [3:0] K_DONE    = 4'd11;

  localparam logic [15:0] ST_OK           = 16'd0;
  localparam logic [15:0] ST_CHASSIS_LONG = 16'd1;
  localparam logic [15:0] ST_BAD_TLV      = 16'd2;
  localparam logic [15:0] ST_TRUNCATED    = 16'd3;

  localparam logic [3:0] TLV_END   = 4'd0;
  localparam logic [6:0] TLV_CH    = 7'd1;
  localparam logic [6:0] TLV_PT    = 7'd2;
  localparam logic [6:0] TLV_TTL   = 7'd3;
  localparam logic [6:0] TLV_PDESC = 7'd4;
  localparam logic [6:0] TLV_SDESC = 7'd6;
  localparam logic [6:0] TLV_CAPS  = 7'd7;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  src_port;
    logic [7:0]  index;
    logic [15:0] value;
    logic        final_res;
  } res_t;

  // Results produced by one accepted byte, in order, item[0] first.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [MAX_RES-1:0] item;
  } res_bundle_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] index,
                                  logic [15:0] value, logic fin);
    res_t r;
    r.kind      = kind;
    r.src_port  = 8'd0;
    r.index     = index;
    r.value     = value;
    r.final_res = fin;
    return r;
  endfunction

endpackage

FILE: rtl/ltp_res_fifo.sv
`timescale 1ns / 1ps

module ltp_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltp_pkg::res_bundle_t push_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output ltp_pkg::res_t       data_o
);

  ltp_pkg::res_t mem [ltp_pkg::FIFO_DEPTH];

  logic [ltp_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ltp_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ltp_pkg::FIFO_CW-1:0] count_q, count_d;
  logic                        do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;
  // Room for a full bundle, independent of this cycle's pop.
  assign room_o  = (count_q <= ltp_pkg::FIFO_CW'(ltp_pkg::FIFO_DEPTH - ltp_pkg::MAX_RES));

  always_comb begin
    wr_ptr_d = wr_ptr_q + ltp_pkg::FIFO_AW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + ltp_pkg::FIFO_AW'(do_pop);
    count_d  = count_q + ltp_pkg::FIFO_CW'(push_i.cnt) - ltp_pkg::FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ltp_pkg::MAX_RES; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem[wr_ptr_q + ltp_pkg::FIFO_AW'(i)] <= push_i.item[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ltp_pkg::FIFO_CW'(ltp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0 && !do_pop) |=>
      count_q == $past(count_q) + ltp_pkg::FIFO_CW'($past(push_i.cnt)))
    else $error("queue count does not follow pushes");

endmodule

FILE: rtl/lldp_tlv_parser_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata = {port, data}, tlast = last byte of the frame
// m_axis    out        tdata = {value, index, src_port}, tuser = kind,
//                      tlast = done item of a frame
// cfg       in         cfg_wdata_i = enable (no read-back)
//
// One byte is taken per clock while there is room; its results are registered into the queue.
// Results leave at one per clock from an eight-entry queue, and a byte is
// taken only while three entries are free, so bytes that yield two or three
// results can slow the input when the output side drains at one per clock.
// Reset is asynchronous: the parser waits for a chassis header, enable is
// one and the queue is empty. A stall on the output never loses a result.

module lldp_tlv_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data, [15:8] port
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] src_port, [15:8] index, [31:16] value
  output logic [3:0]  m_axis_tuser,   // [3:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic             enable_q;
  ltp_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       fhb_q, fhb_d;
  logic [8:0]       rem_q, rem_d;
  logic [8:0]       off_q, off_d;
  logic [6:0]       tlv_q, tlv_d;
  logic [15:0]      word_q, word_d;
  logic             skip_q, skip_d;
  logic [7:0]       fport_q, fport_d;
  logic             ctl_q, ctl_d;

  logic                 in_acc;
  logic                 room;
  logic [7:0]           b;
  logic [8:0]           len;
  logic [6:0]           typ;
  ltp_pkg::res_bundle_t bnd;
  ltp_pkg::res_bundle_t push;
  ltp_pkg::res_t        out_res;

  assign b      = s_axis_tdata[7:0];
  assign len    = {fhb_q[0], b};
  assign typ    = fhb_q[7:1];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  always_comb begin
    logic [1:0]  n;
    logic [15:0] status;
    n       = 2'd0;
    bnd     = '0;
    status  = ltp_pkg::ST_OK;
    phase_d = phase_q;
    fhb_d   = fhb_q;
    rem_d   = rem_q;
    off_d   = off_q;
    tlv_d   = tlv_q;
    word_d  = word_q;
    skip_d  = skip_q;
    fport_d = fport_q;
    ctl_d   = ctl_q;

    if (!enable_q) begin
      skip_d = !s_axis_tlast;
    end else if (!skip_q) begin
      if (phase_q == ltp_pkg::PH_CH_HDR1) begin
        fport_d = s_axis_tdata[15:8];
        ctl_d   = 1'b0;
      end
      unique case (phase_q)
        ltp_pkg::PH_CH_HDR1, ltp_pkg::PH_PT_HDR1,
        ltp_pkg::PH_TTL_HDR1, ltp_pkg::PH_OPT_HDR1: begin
          fhb_d   = b;
          phase_d = ltp_pkg::phase_e'(phase_q + 4'd1);
        end
        ltp_pkg::PH_CH_HDR2, ltp_pkg::PH_PT_HDR2: begin
          if (typ != ((phase_q == ltp_pkg::PH_CH_HDR2) ? ltp_pkg::TLV_CH : ltp_pkg::TLV_PT)
              || len < 9'd2 || len > 9'd256) begin
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, ltp_pkg::ST_BAD_TLV, 1'b1);
            n = n + 2'd1;
            skip_d = 1'b1;
          end else begin
            tlv_d = typ;
            rem_d = len - 9'd1;
            off_d = 9'd0;
            if (phase_q == ltp_pkg::PH_CH_HDR2) begin
              ctl_d = (len - 9'd1) > 9'(ltp_pkg::ID_LEN);
            end
            phase_d = ltp_pkg::phase_e'(phase_q + 4'd1);
          end
        end
        ltp_pkg::PH_CH_SUB, ltp_pkg::PH_PT_SUB: begin
          bnd.item[n] = ltp_pkg::mk_res((phase_q == ltp_pkg::PH_CH_SUB) ?
                          ltp_pkg::K_CH_SUB : ltp_pkg::K_PT_SUB, 8'd0, {8'd0, b}, 1'b0);
          n = n + 2'd1;
          phase_d = ltp_pkg::phase_e'(phase_q + 4'd1);
        end
        ltp_pkg::PH_CH_ID, ltp_pkg::PH_PT_ID: begin
          if (off_q < 9'(ltp_pkg::ID_LEN)) begin
            bnd.item[n] = ltp_pkg::mk_res((phase_q == ltp_pkg::PH_CH_ID) ?
                            ltp_pkg::K_CH_BYTE : ltp_pkg::K_PT_BYTE,
                            off_q[7:0], {8'd0, b}, 1'b0);
            n = n + 2'd1;
          end
          off_d = off_q + 9'd1;
          rem_d = rem_q - 9'd1;
          if (rem_d == 9'd0) begin
            if (phase_q == ltp_pkg::PH_CH_ID) begin
              // The chassis length item reports the full length, even if cut.
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_LEN, 8'd0, {7'd0, off_d}, 1'b0);
              phase_d = ltp_pkg::PH_PT_HDR1;
            end else begin
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_LEN, 8'd1,
                              (off_d < 9'(ltp_pkg::ID_LEN)) ? {7'd0, off_d} :
                              16'(ltp_pkg::ID_LEN), 1'b0);
              phase_d = ltp_pkg::PH_TTL_HDR1;
            end
            n = n + 2'd1;
          end
        end
        ltp_pkg::PH_TTL_HDR2: begin
          if (typ != ltp_pkg::TLV_TTL || len < 9'd2) begin
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, ltp_pkg::ST_BAD_TLV, 1'b1);
            n = n + 2'd1;
            skip_d = 1'b1;
          end else begin
            tlv_d   = typ;
            rem_d   = len;
            off_d   = 9'd0;
            word_d  = 16'd0;
            phase_d = ltp_pkg::PH_TTL_VAL;
          end
        end
        ltp_pkg::PH_TTL_VAL: begin
          if (off_q < 9'd2) begin
            word_d = {word_q[7:0], b};
          end
          if (off_q == 9'd1) begin
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_TTL, 8'd0, word_d, 1'b0);
            n = n + 2'd1;
          end
          off_d = off_q + 9'd1;
          rem_d = rem_q - 9'd1;
          if (rem_d == 9'd0) begin
            phase_d = ltp_pkg::PH_OPT_HDR1;
          end
        end
        ltp_pkg::PH_OPT_HDR2: begin
          tlv_d  = typ;
          off_d  = 9'd0;
          rem_d  = len;
          word_d = 16'd0;
          if (typ == 7'(ltp_pkg::TLV_END)) begin
            if (len != 9'd0) begin
              status = ltp_pkg::ST_BAD_TLV;
            end else if (ctl_q) begin
              status = ltp_pkg::ST_CHASSIS_LONG;
            end else begin
              status = ltp_pkg::ST_OK;
            end
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, status, 1'b1);
            n = n + 2'd1;
            skip_d = 1'b1;
          end else if (typ >= ltp_pkg::TLV_PDESC && typ <= ltp_pkg::TLV_SDESC) begin
            if (len == 9'd0) begin
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_LEN, 8'(typ) - 8'd2, 16'd0, 1'b0);
              n = n + 2'd1;
              phase_d = ltp_pkg::PH_OPT_HDR1;
            end else begin
              phase_d = ltp_pkg::PH_OPT_VAL;
            end
          end else if (typ == ltp_pkg::TLV_CAPS && len >= 9'd4) begin
            phase_d = ltp_pkg::PH_OPT_VAL;
          end else begin
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, ltp_pkg::ST_BAD_TLV, 1'b1);
            n = n + 2'd1;
            skip_d = 1'b1;
          end
        end
        ltp_pkg::PH_OPT_VAL: begin
          if (tlv_q == ltp_pkg::TLV_CAPS) begin
            if (off_q < 9'd4) begin
              word_d = {word_q[7:0], b};
            end
            if (off_q == 9'd1) begin
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_CAPS, 8'd0, word_d, 1'b0);
              n = n + 2'd1;
              word_d = 16'd0;
            end else if (off_q == 9'd3) begin
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_CAPS_EN, 8'd0, word_d, 1'b0);
              n = n + 2'd1;
            end
          end else if ({1'b0, off_q} < 10'(ltp_pkg::DESCR_LEN)) begin
            // Text kinds follow the TLV type: description, name, system text.
            bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_TEXT0 + {2'd0, tlv_q[1:0]},
                            off_q[7:0], {8'd0, b}, 1'b0);
            n = n + 2'd1;
          end
          off_d = off_q + 9'd1;
          rem_d = rem_q - 9'd1;
          if (rem_d == 9'd0) begin
            if (tlv_q != ltp_pkg::TLV_CAPS) begin
              bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_LEN, 8'(tlv_q) - 8'd2,
                              ({1'b0, off_d} < 10'(ltp_pkg::DESCR_LEN)) ? {7'd0, off_d} :
                              16'(ltp_pkg::DESCR_LEN), 1'b0);
              n = n + 2'd1;
            end
            phase_d = ltp_pkg::PH_OPT_HDR1;
          end
        end
        default: begin
          bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, ltp_pkg::ST_BAD_TLV, 1'b1);
          n = n + 2'd1;
          skip_d = 1'b1;
        end
      endcase
      // A frame that ends before its end TLV closes with a truncated status.
      if (s_axis_tlast && !skip_d) begin
        bnd.item[n] = ltp_pkg::mk_res(ltp_pkg::K_DONE, 8'd0, ltp_pkg::ST_TRUNCATED, 1'b1);
        n = n + 2'd1;
        skip_d = 1'b1;
      end
    end

    if (s_axis_tlast) begin
      phase_d = ltp_pkg::PH_CH_HDR1;
      skip_d  = 1'b0;
    end

    for (int i = 0; i < ltp_pkg::MAX_RES; i++) begin
      bnd.item[i].src_port = fport_d;
    end
    bnd.cnt = n;
  end

  always_comb begin
    push     = bnd;
    push.cnt = in_acc ? bnd.cnt : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ltp_pkg::PH_CH_HDR1;
      fhb_q   <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      tlv_q   <= '0;
      word_q  <= '0;
      skip_q  <= 1'b0;
      fport_q <= '0;
      ctl_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      fhb_q   <= fhb_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      tlv_q   <= tlv_d;
      word_q  <= word_d;
      skip_q  <= skip_d;
      fport_q <= fport_d;
      ctl_q   <= ctl_d;
    end
  end

  ltp_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.value, out_res.index, out_res.src_port};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.final_res;

  a_disabled_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |-> bnd.cnt == 2'd0)
    else $error("results produced while disabled");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> bnd.cnt == 2'd0)
    else $error("results produced while skipping a frame");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (phase_q == ltp_pkg::PH_CH_HDR1 && !skip_q))
    else $error("parser not rearmed after the last byte");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bnd.cnt == 2'd2) |-> !bnd.item[0].final_res)
    else $error("done item is followed by another result");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RESET_CYCLES  = 4;

  // TLV types that only the stimulus needs.
  localparam logic [6:0] TLV_SNAME   = 7'd5;
  localparam logic [6:0] TLV_UNKNOWN = 7'd9;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] data, [15:8] port
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // [7:0] src_port, [15:8] index, [31:16] value
  logic [3:0]  m_axis_tuser;   // [3:0] kind
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;

  lldp_tlv_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Parser state as the block should hold it.
  bit                  parse_en     = 1'b1;
  ltp_pkg::phase_e     parse_phase  = ltp_pkg::PH_CH_HDR1;
  logic [7:0]          hdr_first    = '0;
  logic [8:0]          val_left     = '0;
  logic [8:0]          val_pos      = '0;
  logic [6:0]          cur_type     = '0;
  logic [15:0]         word_acc     = '0;
  bit                  frame_skip   = 1'b0;
  logic [7:0]          frame_src    = '0;
  bit                  chassis_long = 1'b0;
  int                  fields_this_byte = 0;
  ltp_pkg::res_t       fields_due[$];

  logic [7:0]  frame_bytes[$];
  bit          idle_on    = 1'b1;
  int          mismatches = 0;
  int unsigned rdy_left   = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned gap_len();
    if ($urandom_range(9, 0) < 8) begin
      return $urandom_range(2, 0);
    end
    return $urandom_range(30, 10);
  endfunction

  function automatic logic [15:0] clip_len(input logic [8:0] n, input int unsigned lim);
    return (int'(n) < int'(lim)) ? 16'(n) : 16'(lim);
  endfunction

  function automatic void push_field(input logic [3:0] kind, input logic [7:0] idx,
                                     input logic [15:0] val, input logic fin);
    ltp_pkg::res_t r;
    if (fields_this_byte >= int'(ltp_pkg::MAX_RES)) return;
    r.kind      = kind;
    r.src_port  = frame_src;
    r.index     = idx;
    r.value     = val;
    r.final_res = fin;
    fields_due.push_back(r);
    fields_this_byte++;
  endfunction

  function automatic void finish_frame(input logic [15:0] status);
    push_field(ltp_pkg::K_DONE, 8'd0, status, 1'b1);
    frame_skip = 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [8:0] len;
    logic [6:0] typ;
    len = {hdr_first[0], b};
    typ = hdr_first[7:1];
    case (parse_phase) inside
      ltp_pkg::PH_CH_HDR1, ltp_pkg::PH_PT_HDR1, ltp_pkg::PH_TTL_HDR1,
      ltp_pkg::PH_OPT_HDR1: begin
        hdr_first   = b;
        parse_phase = ltp_pkg::phase_e'(parse_phase + 4'd1);
      end
      ltp_pkg::PH_CH_HDR2, ltp_pkg::PH_PT_HDR2: begin
        if (typ != ((parse_phase == ltp_pkg::PH_CH_HDR2) ? ltp_pkg::TLV_CH : ltp_pkg::TLV_PT)
            || len < 9'd2 || len > 9'd256) begin
          finish_frame(ltp_pkg::ST_BAD_TLV);
        end else begin
          cur_type = typ;
          val_left = len - 9'd1;
          val_pos  = 9'd0;
          if (parse_phase == ltp_pkg::PH_CH_HDR2) begin
            chassis_long = (int'(len) - 1) > int'(ltp_pkg::ID_LEN);
          end
          parse_phase = ltp_pkg::phase_e'(parse_phase + 4'd1);
        end
      end
      ltp_pkg::PH_CH_SUB, ltp_pkg::PH_PT_SUB: begin
        push_field((parse_phase == ltp_pkg::PH_CH_SUB) ? ltp_pkg::K_CH_SUB : ltp_pkg::K_PT_SUB,
                   8'd0, {8'd0, b}, 1'b0);
        parse_phase = ltp_pkg::phase_e'(parse_phase + 4'd1);
      end
      ltp_pkg::PH_CH_ID, ltp_pkg::PH_PT_ID: begin
        if (int'(val_pos) < int'(ltp_pkg::ID_LEN)) begin
          push_field((parse_phase == ltp_pkg::PH_CH_ID) ? ltp_pkg::K_CH_BYTE :
                     ltp_pkg::K_PT_BYTE, val_pos[7:0], {8'd0, b}, 1'b0);
        end
        val_pos  = val_pos + 9'd1;
        val_left = val_left - 9'd1;
        if (val_left == 9'd0) begin
          if (parse_phase == ltp_pkg::PH_CH_ID) begin
            push_field(ltp_pkg::K_LEN, 8'd0, 16'(val_pos), 1'b0);
            parse_phase = ltp_pkg::PH_PT_HDR1;
          end else begin
            push_field(ltp_pkg::K_LEN, 8'd1, clip_len(val_pos, ltp_pkg::ID_LEN), 1'b0);
            parse_phase = ltp_pkg::PH_TTL_HDR1;
          end
        end
      end
      ltp_pkg::PH_TTL_HDR2: begin
        if (typ != ltp_pkg::TLV_TTL || len < 9'd2) begin
          finish_frame(ltp_pkg::ST_BAD_TLV);
        end else begin
          cur_type    = typ;
          val_left    = len;
          val_pos     = 9'd0;
          word_acc    = 16'd0;
          parse_phase = ltp_pkg::PH_TTL_VAL;
        end
      end
      ltp_pkg::PH_TTL_VAL: begin
        if (val_pos < 9'd2) begin
          word_acc = {word_acc[7:0], b};
        end
        if (val_pos == 9'd1) begin
          push_field(ltp_pkg::K_TTL, 8'd0, word_acc, 1'b0);
        end
        val_pos  = val_pos + 9'd1;
        val_left = val_left - 9'd1;
        if (val_left == 9'd0) begin
          parse_phase = ltp_pkg::PH_OPT_HDR1;
        end
      end
      ltp_pkg::PH_OPT_HDR2: begin
        cur_type = typ;
        val_pos  = 9'd0;
        val_left = len;
        word_acc = 16'd0;
        if (typ == 7'(ltp_pkg::TLV_END)) begin
          if (len != 9'd0) begin
            finish_frame(ltp_pkg::ST_BAD_TLV);
          end else if (chassis_long) begin
            finish_frame(ltp_pkg::ST_CHASSIS_LONG);
          end else begin
            finish_frame(ltp_pkg::ST_OK);
          end
        end else if (typ >= ltp_pkg::TLV_PDESC && typ <= ltp_pkg::TLV_SDESC) begin
          if (len == 9'd0) begin
            push_field(ltp_pkg::K_LEN, 8'(typ) - 8'd2, 16'd0, 1'b0);
            parse_phase = ltp_pkg::PH_OPT_HDR1;
          end else begin
            parse_phase = ltp_pkg::PH_OPT_VAL;
          end
        end else if (typ == ltp_pkg::TLV_CAPS && len >= 9'd4) begin
          parse_phase = ltp_pkg::PH_OPT_VAL;
        end else begin
          finish_frame(ltp_pkg::ST_BAD_TLV);
        end
      end
      ltp_pkg::PH_OPT_VAL: begin
        if (cur_type == ltp_pkg::TLV_CAPS) begin
          if (val_pos < 9'd4) begin
            word_acc = {word_acc[7:0], b};
          end
          if (val_pos == 9'd1) begin
            push_field(ltp_pkg::K_CAPS, 8'd0, word_acc, 1'b0);
            word_acc = 16'd0;
          end else if (val_pos == 9'd3) begin
            push_field(ltp_pkg::K_CAPS_EN, 8'd0, word_acc, 1'b0);
          end
        end else if (int'(val_pos) < int'(ltp_pkg::DESCR_LEN)) begin
          push_field(ltp_pkg::K_TEXT0 + 4'(cur_type - ltp_pkg::TLV_PDESC), val_pos[7:0],
                     {8'd0, b}, 1'b0);
        end
        val_pos  = val_pos + 9'd1;
        val_left = val_left - 9'd1;
        if (val_left == 9'd0) begin
          if (cur_type != ltp_pkg::TLV_CAPS) begin
            push_field(ltp_pkg::K_LEN, 8'(cur_type) - 8'd2,
                       clip_len(val_pos, ltp_pkg::DESCR_LEN), 1'b0);
          end
          parse_phase = ltp_pkg::PH_OPT_HDR1;
        end
      end
      default: begin
        finish_frame(ltp_pkg::ST_BAD_TLV);
      end
    endcase
  endfunction

  function automatic void model_step(input logic [7:0] b, input logic [7:0] p,
                                     input logic last);
    fields_this_byte = 0;
    if (!parse_en) begin
      frame_skip = !last;
      if (last) begin
        parse_phase = ltp_pkg::PH_CH_HDR1;
      end
      return;
    end
    if (!frame_skip) begin
      if (parse_phase == ltp_pkg::PH_CH_HDR1) begin
        frame_src    = p;
        chassis_long = 1'b0;
      end
      parse_byte(b);
      if (last && !frame_skip) begin
        finish_frame(ltp_pkg::ST_TRUNCATED);
      end
    end
    if (last) begin
      parse_phase = ltp_pkg::PH_CH_HDR1;
      frame_skip  = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input ltp_pkg::res_t exp,
                                 input ltp_pkg::res_t got);
    $display("mismatch (%s): expected kind/port/index/value/final %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
             what, exp.kind, exp.src_port, exp.index, exp.value, exp.final_res,
             got.kind, got.src_port, got.index, got.value, got.final_res);
    mismatches++;
  endtask

  task automatic check_result();
    ltp_pkg::res_t exp;
    ltp_pkg::res_t got;
    got.kind      = m_axis_tuser;
    got.src_port  = m_axis_tdata[7:0];
    got.index     = m_axis_tdata[15:8];
    got.value     = m_axis_tdata[31:16];
    got.final_res = m_axis_tlast;
    if (fields_due.size() == 0) begin
      report_mismatch("unexpected result", got, got);
      return;
    end
    exp = fields_due.pop_front();
    if (got !== exp) begin
      report_mismatch("wrong result", exp, got);
    end
  endtask

  // Results are checked first: a request taken at the same edge yields results only later.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (cfg_we_i) begin
        parse_en = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        model_step(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_left      <= 0;
    end else if (!idle_on) begin
      m_axis_tready <= 1'b1;
      rdy_left      <= 0;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rdy_left      <= gap_len();
    end else begin
      m_axis_tready <= 1'b1;
      rdy_left      <= $urandom_range(5, 0);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic [7:0] port,
                           input logic last);
    int unsigned gap;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {port, data};
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  task automatic send_frame(input logic [7:0] port);
    int unsigned n;
    n = frame_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(frame_bytes[i], port, i == n - 1);
    end
    frame_bytes.delete();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (fields_due.size() != 0 || m_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void add_header(input logic [6:0] typ, input logic [8:0] len);
    frame_bytes.push_back({typ, len[8]});
    frame_bytes.push_back(len[7:0]);
  endfunction

  function automatic void add_tlv(input logic [6:0] typ, input logic [8:0] len);
    add_header(typ, len);
    for (int i = 0; i < int'(len); i++) begin
      frame_bytes.push_back(8'($urandom_range(255, 0)));
    end
  endfunction

  // Chassis ID, port ID and TTL TLVs; ID lengths exclude the subtype byte.
  function automatic void add_ids(input int unsigned ch_len, input int unsigned pt_len,
                                  input int unsigned ttl_len);
    add_tlv(ltp_pkg::TLV_CH, 9'(ch_len + 1));
    add_tlv(ltp_pkg::TLV_PT, 9'(pt_len + 1));
    add_tlv(ltp_pkg::TLV_TTL, 9'(ttl_len));
  endfunction

  function automatic logic [7:0] pick_port();
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic test_full_frame();
    add_ids(4, 3, 2);
    add_tlv(TLV_SNAME, 9'd3);
    add_tlv(ltp_pkg::TLV_CAPS, 9'd4);
    add_tlv(ltp_pkg::TLV_PDESC, 9'd0);
    add_tlv(ltp_pkg::TLV_SDESC, 9'd2);
    add_tlv(7'(ltp_pkg::TLV_END), 9'd0);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_chassis_long();
    idle_on = 1'b0;
    add_ids(ltp_pkg::ID_LEN + 1, 1, 3);
    add_tlv(7'(ltp_pkg::TLV_END), 9'd0);
    send_frame(pick_port());
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_truncated();
    add_ids(2, 2, 2);
    void'(frame_bytes.pop_back());
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_bad_order();
    add_tlv(ltp_pkg::TLV_PT, 9'd2);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_ttl_short();
    add_ids(1, 1, 1);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_caps_short();
    add_ids(1, 1, 2);
    add_header(ltp_pkg::TLV_CAPS, 9'd3);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_end_length();
    add_ids(1, 1, 2);
    add_tlv(7'(ltp_pkg::TLV_END), 9'd1);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_unknown_type();
    add_ids(1, 1, 2);
    add_tlv(TLV_UNKNOWN, 9'd2);
    send_frame(pick_port());
    wait_idle();
  endtask

  task automatic test_disabled();
    logic [7:0] port;
    port = pick_port();
    add_ids(1, 1, 2);
    write_enable(1'b0);
    for (int i = 0; i < 3; i++) begin
      send_byte(frame_bytes.pop_front(), port, 1'b0);
    end
    wait_idle();
    // The rest of a frame that began while disabled stays ignored.
    write_enable(1'b1);
    send_frame(port);
    wait_idle();
    add_ids(1, 1, 2);
    add_tlv(7'(ltp_pkg::TLV_END), 9'd0);
    send_frame(pick_port());
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_frame();
    test_chassis_long();
    test_truncated();
    test_bad_order();
    test_ttl_short();
    test_caps_short();
    test_end_length();
    test_unknown_type();
    test_disabled();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
